FILE: rtl/bcd_pkg.sv
// Shared types and constants of the BC1/BC2/BC3 block decoder.
package bcd_pkg;

  // Format register codes; the unused code decodes as BC1
  localparam logic [1:0] FMT_BC1  = 2'd0;
  localparam logic [1:0] FMT_BC2  = 2'd1;
  localparam logic [1:0] FMT_BC3  = 2'd2;
  localparam logic [1:0] FMT_RSVD = 2'd3;

  // Truncating divides by 3, 5 and 7 as multiply and shift, exact over the sum ranges used
  localparam logic [9:0]  RECIP3  = 10'd683;
  localparam int          SHIFT3  = 11;
  localparam logic [10:0] RECIP5  = 11'd1639;
  localparam int          SHIFT5  = 13;
  localparam logic [11:0] RECIP7  = 12'd2341;
  localparam int          SHIFT7  = 14;

  localparam logic [3:0] LAST_TEXEL = 4'd15;

  // Colour palette (four entries per channel) and BC3 alpha palette
  typedef struct packed {
    logic [3:0][7:0] r;
    logic [3:0][7:0] g;
    logic [3:0][7:0] b;
    logic [3:0][7:0] a;
    logic [7:0][7:0] ap;
  } pal_t;

  // Everything the texel stage needs from one block
  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] cidx;
    logic [63:0] lo;
    pal_t        pal;
  } blk_t;

endpackage

FILE: rtl/bcd_color_lane.sv
// One colour channel lane: palette entries 2 and 3, interpolated, or the midpoint and zero in three-colour mode.
module bcd_color_lane import bcd_pkg::*; (
  input  logic [7:0] e0,
  input  logic [7:0] e1,
  input  logic       four_mode,
  output logic [7:0] ent2,
  output logic [7:0] ent3
);

  logic [9:0]  s_a;
  logic [9:0]  s_b;
  logic [8:0]  s_h;
  logic [19:0] p_a;
  logic [19:0] p_b;

  assign s_a = {1'b0, e0, 1'b0} + {2'b00, e1};
  assign s_b = {2'b00, e0} + {1'b0, e1, 1'b0};
  assign s_h = {1'b0, e0} + {1'b0, e1};
  assign p_a = s_a * RECIP3;
  assign p_b = s_b * RECIP3;

  always_comb begin
    if (four_mode) begin
      ent2 = p_a[SHIFT3 +: 8];
      ent3 = p_b[SHIFT3 +: 8];
    end else begin
      ent2 = s_h[8:1];
      ent3 = 8'd0;
    end
  end

endmodule

FILE: rtl/bcd_alpha_lane.sv
// One alpha lane: one alpha palette entry, interpolated or a fixed value.
module bcd_alpha_lane import bcd_pkg::*; (
  input  logic [10:0] s7,
  input  logic [10:0] s5,
  input  logic        eight_mode,
  input  logic        fixed_en,
  input  logic [7:0]  fixed_val,
  output logic [7:0]  ent
);

  logic [22:0] p7;
  logic [21:0] p5;

  assign p7 = s7 * RECIP7;
  assign p5 = s5 * RECIP5;

  always_comb begin
    if (eight_mode) begin
      ent = p7[SHIFT7 +: 8];
    end else if (fixed_en) begin
      ent = fixed_val;
    end else begin
      ent = p5[SHIFT5 +: 8];
    end
  end

endmodule

FILE: rtl/bcd_texel_merge.sv
// Merge stage: holds one block's palettes and emits its sixteen texels.
module bcd_texel_merge import bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ld_vld,
  input  blk_t        ld_blk,
  output logic        ld_rdy,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  blk_t        blk_r;
  logic        b_vld_r, b_vld_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        o_vld_r, o_vld_nxt;
  logic [39:0] o_data_r;
  logic        o_last_r;

  logic        issue;
  logic        load;
  logic [1:0]  ci;
  logic [2:0]  ai;
  logic [3:0]  nib;
  logic [5:0]  apos;
  logic [7:0]  alpha;

  assign issue  = b_vld_r && (!o_vld_r || out_tready);
  assign ld_rdy = !b_vld_r || (issue && cnt_r == LAST_TEXEL);
  assign load   = ld_vld && ld_rdy;

  assign ci   = blk_r.cidx[{cnt_r, 1'b0} +: 2];
  assign apos = 6'd16 + {1'b0, cnt_r, 1'b0} + {2'b00, cnt_r};
  assign ai   = blk_r.lo[apos +: 3];
  assign nib  = blk_r.lo[{cnt_r, 2'b00} +: 4];

  always_comb begin
    case (blk_r.fmt)
      FMT_BC2: alpha = {nib, nib};
      FMT_BC3: alpha = blk_r.pal.ap[ai];
      default: alpha = blk_r.pal.a[ci];
    endcase
  end

  always_comb begin
    b_vld_nxt = b_vld_r;
    cnt_nxt   = cnt_r;
    if (issue) begin
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == LAST_TEXEL) begin
        b_vld_nxt = 1'b0;
      end
    end
    if (load) begin
      b_vld_nxt = 1'b1;
      cnt_nxt   = 4'd0;
    end
    if (issue) begin
      o_vld_nxt = 1'b1;
    end else if (out_tready) begin
      o_vld_nxt = 1'b0;
    end else begin
      o_vld_nxt = o_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      cnt_r   <= 4'd0;
      o_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
      cnt_r   <= cnt_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blk_r <= ld_blk;
    end
    if (issue) begin
      o_data_r <= {4'b0000, cnt_r, alpha, blk_r.pal.b[ci], blk_r.pal.g[ci], blk_r.pal.r[ci]};
      o_last_r <= (cnt_r == LAST_TEXEL);
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

`ifndef SYNTHESIS
  // last texel of a block frees the stage for the next one
  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    issue && cnt_r == LAST_TEXEL && !load |=> !b_vld_r)
    else $error("texel stage still busy after last texel");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> b_vld_r && cnt_r == 4'd0)
    else $error("new block does not start at texel 0");

  a_tlast_idx: assert property (@(posedge clk) disable iff (!rst_n)
    o_vld_r |-> (o_last_r == (o_data_r[35:32] == LAST_TEXEL)))
    else $error("tlast does not match texel index");
`endif

endmodule

FILE: rtl/bc1_bc2_bc3_block_decoder.sv
// Top level of the BC1/BC2/BC3 block decoder: input stage, palette lanes, merge stage.
//
//  channel | direction | payload (low bit first)                  | handshake
//  in_     | input     | tdata[127:0] block_low, block_high      | tvalid/tready
//  out_    | output    | tdata[39:0] red,green,blue,alpha,index  | tvalid/tready, tlast
//  cfg_    | input     | wdata[1:0] format                       | wen
//
// Unless out_tready stalls, the merge stage emits one texel per cycle from its
// palette registers and the output register takes one texel a cycle; the merge
// stage loads the next block as it issues the current one's last texel. Blocks pass
// input stage, lanes, merge stage; the next waits in the input stage while one drains.
// rst_n is synchronous, active low; it clears format to BC1 and empties all stages.
// A stalled out_tready holds the texel and stalls the merge and input stages.
module bc1_bc2_bc3_block_decoder import bcd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_wdata,   // format
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,    // block_low[63:0], block_high[127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24],
                                    // texel_index[35:32], zero fill
  output logic         out_tlast
);

  logic [1:0]  fmt_r;
  logic        a_vld_r, a_vld_nxt;
  logic [1:0]  a_fmt_r;
  logic [63:0] a_chalf_r;
  logic [63:0] a_lo_r;
  logic [10:0] a_s7_r [6];
  logic [10:0] a_s5_r [4];

  logic        in_acc;
  logic        ld_rdy;
  logic        a_move;
  logic        fmt_alpha;
  logic [7:0]  a0_in, a1_in;

  assign in_acc    = in_tvalid && in_tready;
  assign a_move    = a_vld_r && ld_rdy;
  assign in_tready = !a_vld_r || ld_rdy;
  assign fmt_alpha = (fmt_r == FMT_BC2) || (fmt_r == FMT_BC3);
  assign a0_in     = in_tdata[7:0];
  assign a1_in     = in_tdata[15:8];

  always_comb begin
    if (in_acc) begin
      a_vld_nxt = 1'b1;
    end else if (a_move) begin
      a_vld_nxt = 1'b0;
    end else begin
      a_vld_nxt = a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_BC1;
      a_vld_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        fmt_r <= cfg_wdata;
      end
      a_vld_r <= a_vld_nxt;
    end
  end

  // Capture the block with the alpha weighted sums ready for the lanes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_fmt_r   <= fmt_r;
      a_lo_r    <= in_tdata[63:0];
      a_chalf_r <= fmt_alpha ? in_tdata[127:64] : in_tdata[63:0];
      for (int k = 1; k < 7; k++) begin
        a_s7_r[k-1] <= 11'(7 - k) * {3'b000, a0_in} + 11'(k) * {3'b000, a1_in};
      end
      for (int k = 1; k < 5; k++) begin
        a_s5_r[k-1] <= 11'(5 - k) * {3'b000, a0_in} + 11'(k) * {3'b000, a1_in};
      end
    end
  end

  // Endpoint expansion
  logic [15:0] c0, c1;
  logic [7:0]  e0 [3];
  logic [7:0]  e1 [3];
  logic [7:0]  ent2 [3];
  logic [7:0]  ent3 [3];
  logic        four_mode;

  assign c0 = a_chalf_r[15:0];
  assign c1 = a_chalf_r[31:16];
  assign e0[0] = {c0[15:11], c0[15:13]};
  assign e0[1] = {c0[10:5],  c0[10:9]};
  assign e0[2] = {c0[4:0],   c0[4:2]};
  assign e1[0] = {c1[15:11], c1[15:13]};
  assign e1[1] = {c1[10:5],  c1[10:9]};
  assign e1[2] = {c1[4:0],   c1[4:2]};
  assign four_mode = (a_fmt_r == FMT_BC2) || (a_fmt_r == FMT_BC3) || (c0 > c1);

  for (genvar ch = 0; ch < 3; ch++) begin : g_color
    bcd_color_lane u_lane (
      .e0        (e0[ch]),
      .e1        (e1[ch]),
      .four_mode (four_mode),
      .ent2      (ent2[ch]),
      .ent3      (ent3[ch])
    );
  end

  logic       eight_mode;
  logic [7:0] aent [6];

  assign eight_mode = a_lo_r[7:0] > a_lo_r[15:8];

  for (genvar j = 0; j < 6; j++) begin : g_alpha
    if (j < 4) begin : g_interp
      bcd_alpha_lane u_lane (
        .s7         (a_s7_r[j]),
        .s5         (a_s5_r[j]),
        .eight_mode (eight_mode),
        .fixed_en   (1'b0),
        .fixed_val  (8'd0),
        .ent        (aent[j])
      );
    end else begin : g_fixed
      // six-entry mode ends in fully transparent then fully opaque
      bcd_alpha_lane u_lane (
        .s7         (a_s7_r[j]),
        .s5         (11'd0),
        .eight_mode (eight_mode),
        .fixed_en   (1'b1),
        .fixed_val  ((j == 4) ? 8'd0 : 8'd255),
        .ent        (aent[j])
      );
    end
  end

  blk_t ld_blk;

  always_comb begin
    ld_blk.fmt  = a_fmt_r;
    ld_blk.cidx = a_chalf_r[63:32];
    ld_blk.lo   = a_lo_r;
    ld_blk.pal.r = {ent3[0], ent2[0], e1[0], e0[0]};
    ld_blk.pal.g = {ent3[1], ent2[1], e1[1], e0[1]};
    ld_blk.pal.b = {ent3[2], ent2[2], e1[2], e0[2]};
    ld_blk.pal.a = {(four_mode ? 8'd255 : 8'd0), 8'd255, 8'd255, 8'd255};
    ld_blk.pal.ap = {aent[5], aent[4], aent[3], aent[2], aent[1], aent[0],
                     a_lo_r[15:8], a_lo_r[7:0]};
  end

  bcd_texel_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_vld     (a_vld_r),
    .ld_blk     (ld_blk),
    .ld_rdy     (ld_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && !ld_rdy |=> a_vld_r && $stable(a_lo_r) && $stable(a_chalf_r))
    else $error("input stage lost a waiting block");

  a_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> a_vld_r)
    else $error("accepted block not held in input stage");

  a_fmt_sel: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (fmt_r == FMT_BC2 || fmt_r == FMT_BC3) |=> a_chalf_r == $past(in_tdata[127:64]))
    else $error("wrong colour half selected");
`endif

endmodule

FILE: sim/bc1_bc2_bc3_block_decoder_tb.sv
// Self-checking testbench for the BC1/BC2/BC3 block decoder: directed and random blocks.
module bc1_bc2_bc3_block_decoder_tb;
  import bcd_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] idx;
    logic       last;
  } texel_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         cfg_wen;
  logic [1:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // block_low[63:0], block_high[127:64]
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;  // red, green, blue, alpha, texel_index, zero fill
  logic         out_tlast;

  texel_t     texel_q[$];
  logic [1:0] fmt_cfg;
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_left = 0;

  bc1_bc2_bc3_block_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // Work out the 16 texels of one block under the given format.
  function automatic void predict_texels(input logic [1:0] fmt, input logic [63:0] lo,
                                         input logic [63:0] hi);
    logic [63:0] half;
    logic [15:0] c0, c1;
    logic        four;
    int          e[2][3];
    int          pal[4][4];
    int          ap[8];
    int          ci, a, a0, a1;
    texel_t      t;
    four = (fmt == FMT_BC2) || (fmt == FMT_BC3);
    half = four ? hi : lo;
    c0 = half[15:0];
    c1 = half[31:16];
    e[0][0] = int'({c0[15:11], c0[15:13]});
    e[0][1] = int'({c0[10:5], c0[10:9]});
    e[0][2] = int'({c0[4:0], c0[4:2]});
    e[1][0] = int'({c1[15:11], c1[15:13]});
    e[1][1] = int'({c1[10:5], c1[10:9]});
    e[1][2] = int'({c1[4:0], c1[4:2]});
    for (int k = 0; k < 3; k++) begin
      pal[0][k] = e[0][k];
      pal[1][k] = e[1][k];
      if (four || c0 > c1) begin
        pal[2][k] = (2 * e[0][k] + e[1][k]) / 3;
        pal[3][k] = (e[0][k] + 2 * e[1][k]) / 3;
      end else begin
        pal[2][k] = (e[0][k] + e[1][k]) / 2;
        pal[3][k] = 0;
      end
    end
    pal[0][3] = 255;
    pal[1][3] = 255;
    pal[2][3] = 255;
    pal[3][3] = (four || c0 > c1) ? 255 : 0;

    a0 = int'(lo[7:0]);
    a1 = int'(lo[15:8]);
    ap[0] = a0;
    ap[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k < 7; k++) ap[k + 1] = ((7 - k) * a0 + k * a1) / 7;
    end else begin
      for (int k = 1; k < 5; k++) ap[k + 1] = ((5 - k) * a0 + k * a1) / 5;
      ap[6] = 0;
      ap[7] = 255;
    end

    for (int i = 0; i < 16; i++) begin
      ci = int'(half[32 + 2 * i +: 2]);
      case (fmt)
        FMT_BC2: a = int'(lo[4 * i +: 4]) * 17;
        FMT_BC3: a = ap[lo[16 + 3 * i +: 3]];
        default: a = pal[ci][3];
      endcase
      t.red   = 8'(pal[ci][0]);
      t.green = 8'(pal[ci][1]);
      t.blue  = 8'(pal[ci][2]);
      t.alpha = 8'(a);
      t.idx   = 4'(i);
      t.last  = (i == 15);
      texel_q.push_back(t);
    end
  endfunction

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each texel with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin : check_texel
      texel_t     want;
      logic [7:0] wf[6];
      logic [7:0] gf[6];
      string      fname[6];
      fname = '{"red", "green", "blue", "alpha", "texel_index", "last"};
      if (texel_q.size() == 0) begin
        $display("%0t: texel with no expectation waiting, tdata %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = texel_q.pop_front();
        wf = '{want.red, want.green, want.blue, want.alpha, {4'b0, want.idx},
               {7'b0, want.last}};
        gf = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[31:24],
               {4'b0, out_tdata[35:32]}, {7'b0, out_tlast}};
        for (int k = 0; k < 6; k++) begin
          if (gf[k] !== wf[k]) begin
            $display("%0t: %s expected %0d, got %0d", $time, fname[k], wf[k], gf[k]);
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    predict_texels(fmt_cfg, lo, hi);
  endtask

  // Drop valid and wait until every expected texel has come.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    drain();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= fmt;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    fmt_cfg = fmt;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random block, sometimes with equal colour or alpha endpoints.
  task automatic send_random_block;
    logic [63:0] lo, hi;
    lo = rand64();
    hi = rand64();
    if ($urandom_range(7) == 0) lo[31:16] = lo[15:0];
    if ($urandom_range(7) == 0) hi[31:16] = hi[15:0];
    if ($urandom_range(7) == 0) lo[15:8] = lo[7:0];
    send_block(lo, hi);
  endtask

  task automatic test_bc1_modes;
    set_format(FMT_BC1);
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'hFFFFFFFFFFFFFFFF); // four colours
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0);             // c0 below c1
    send_block({32'hE4E4E4E4, 16'h1234, 16'h1234}, rand64());           // equal endpoints
    send_block(64'h0, 64'h0);
    send_block(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
    send_block({32'h1B1B1B1B, 16'h07E0, 16'hF81F}, rand64());
    drain();
  endtask

  task automatic test_bc2_alpha;
    set_format(FMT_BC2);
    send_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hFFFF, 16'h0000}); // still four colours
    send_block(64'h0123456789ABCDEF, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
    send_block(64'hFFFFFFFFFFFFFFFF, {32'h1B1B1B1B, 16'h8410, 16'h8410});
    drain();
  endtask

  task automatic test_bc3_alpha;
    logic [47:0] ramp;
    for (int i = 0; i < 16; i++) ramp[3 * i +: 3] = i[2:0];
    set_format(FMT_BC3);
    send_block({ramp, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF}); // eight entries
    send_block({ramp, 8'hF0, 8'h10}, {32'hE4E4E4E4, 16'hF800, 16'h001F}); // six plus 0, 255
    send_block({ramp, 8'h80, 8'h80}, rand64());
    send_block({ramp, 8'h00, 8'hFF}, 64'hFFFFFFFFFFFFFFFF);
    send_block({ramp, 8'hFF, 8'h00}, 64'h0);
    drain();
  endtask

  task automatic test_unused_format;
    set_format(FMT_RSVD);
    send_block({32'hE4E4E4E4, 16'h1234, 16'h1234}, 64'hFFFFFFFFFFFFFFFF);
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, rand64());
    drain();
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    int until_switch;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    until_switch  = 0;
    for (int n = 0; n < count; n++) begin
      if (until_switch == 0) begin
        set_format(2'($urandom_range(3)));
        until_switch = $urandom_range(32, 16);
      end
      until_switch--;
      send_random_block();
    end
    drain();
  endtask

  // Hold the receiver off long enough to back up the input.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_format(FMT_BC3);
    hold_left = 300;
    for (int n = 0; n < 10; n++) send_random_block();
    drain();
  endtask

  // Let the block empty out completely between bursts.
  task automatic test_pause;
    send_idle_pct = 8;
    recv_idle_pct = 8;
    for (int n = 0; n < 5; n++) send_random_block();
    drain();
    repeat (20) @(posedge clk);
    for (int n = 0; n < 5; n++) send_random_block();
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = FMT_BC1;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    fmt_cfg    = FMT_BC1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 8;
    recv_idle_pct = 54;
    test_bc1_modes();
    test_bc2_alpha();
    test_bc3_alpha();
    test_unused_format();
    test_random(100, 8, 54);
    test_random(100, 54, 8);
    test_random(100, 0, 0);
    test_backpressure();
    test_pause();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bcd_pkg.sv
rtl/bcd_color_lane.sv
rtl/bcd_alpha_lane.sv
rtl/bcd_texel_merge.sv
rtl/bc1_bc2_bc3_block_decoder.sv
sim/bc1_bc2_bc3_block_decoder_tb.sv
